>>> design/arqsw_pkg.sv
// ---------------------------------------------------------------------------
// ARQ sender window package
// Shared constants, codes and result record for the ARQ sender window block.
// ---------------------------------------------------------------------------
package arqsw_pkg;

  // Retransmit window geometry.
  localparam int WINDOW_DEPTH = 32;
  localparam int TAG_WIDTH    = 16;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = CNT_W + 1;

  // Fixed field widths of the channels.
  localparam int SEQ_W   = 8;
  localparam int COUNT_W = 6;
  localparam int LIMIT_W = 6;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 2;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [0:0] REG_WINDOW_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RESET = LIMIT_W'(8);

  // Backward distance beyond which a sequence number counts as wrapped.
  localparam logic [SEQ_W-1:0] WRAP_DIST = SEQ_W'(150);

  // Sequence state after reset.
  localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK_REQ = 2'd1,
    MODE_ACK_IN  = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_ACK_REQ  = 3'd2,
    KIND_RESEND   = 3'd3,
    KIND_REJECTED = 3'd4
  } kind_t;

  // One result beat.
  typedef struct packed {
    kind_t                kind;
    logic [SEQ_W-1:0]     seq_number;
    logic [TAG_WIDTH-1:0] tag_out;
    logic [COUNT_W-1:0]   window_count;
    logic                 last;
  } result_t;

endpackage

>>> design/arq_sender_window_unit.sv
// ---------------------------------------------------------------------------
// ARQ sender window unit
// Numbers outgoing packets, keeps their tags for retransmit and processes
// arriving acks for the sender side of a sliding-window ARQ link.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (mode, packet_tag, want_ack, ack_seq, ack_generator) enter
//   on the in_valid/in_ready channel. Each beat yields one result beat, or two
//   for a send that also asks for an ack request; the final one has last set.
//   An accepted beat lands in an input register, is worked in one pass of
//   logic and its results are written to the output register.
//   One-result items sustain one item per cycle while out_ready is high; a
//   send with an ack request holds the output for two beats, so the next
//   item waits until the second result leaves the one-entry spill slot
//   behind the single output register.
//   When out_ready is low the output register and spill slot hold, the
//   input register fills and in_ready drops until results drain.
//   Synchronous reset sets next and head sequence to 1, the receiver
//   sequence to 0, empties the window and sets window_limit to 8. The tag
//   store is not cleared; only written entries are ever read.
//   window_limit is written over the APB port at byte address 0; the user
//   writes it only while idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module arq_sender_window_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [arqsw_pkg::MODE_W-1:0]          mode,
  input  logic [arqsw_pkg::TAG_WIDTH-1:0]       packet_tag,
  input  logic                                  want_ack,
  input  logic [arqsw_pkg::SEQ_W-1:0]           ack_seq,
  input  logic [arqsw_pkg::SEQ_W-1:0]           ack_generator,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [arqsw_pkg::KIND_W-1:0]          kind,
  output logic [arqsw_pkg::SEQ_W-1:0]           seq_number,
  output logic [arqsw_pkg::TAG_WIDTH-1:0]       tag_out,
  output logic [arqsw_pkg::COUNT_W-1:0]         window_count,
  output logic                                  last,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [arqsw_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [arqsw_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [arqsw_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  // Configuration register.
  logic [arqsw_pkg::LIMIT_W-1:0] window_limit;

  // Input register.
  logic                              item_valid;
  arqsw_pkg::mode_t                  item_mode;
  logic [arqsw_pkg::TAG_WIDTH-1:0]   item_tag;
  logic                              item_areq;
  logic [arqsw_pkg::SEQ_W-1:0]       item_aseq;
  logic [arqsw_pkg::SEQ_W-1:0]       item_agen;

  // Window state.
  logic [arqsw_pkg::SEQ_W-1:0]       next_seq;
  logic [arqsw_pkg::SEQ_W-1:0]       receiver_seq;
  logic [arqsw_pkg::SEQ_W-1:0]       head_seq;
  logic [arqsw_pkg::CNT_W-1:0]       held_count;
  logic [arqsw_pkg::PTR_W-1:0]       read_pos;
  logic [arqsw_pkg::TAG_WIDTH-1:0]   tag_store [arqsw_pkg::WINDOW_DEPTH];

  logic [arqsw_pkg::SEQ_W-1:0]       next_seq_next;
  logic [arqsw_pkg::SEQ_W-1:0]       receiver_seq_next;
  logic [arqsw_pkg::SEQ_W-1:0]       head_seq_next;
  logic [arqsw_pkg::CNT_W-1:0]       held_count_next;
  logic [arqsw_pkg::PTR_W-1:0]       read_pos_next;

  // Output register and spill slot for the second result.
  logic                              out_full;
  arqsw_pkg::result_t                out_q;
  logic                              pend_valid;
  arqsw_pkg::result_t                pend_q;

  // Pass results.
  arqsw_pkg::result_t                res0;
  arqsw_pkg::result_t                res1;
  logic                              res_two;
  logic                              store_wr;
  logic [arqsw_pkg::PTR_W-1:0]       wpos;

  // Intermediate values of the pass.
  logic                              window_full;
  logic [arqsw_pkg::SUM_W-1:0]       wsum;
  logic                              agen_newer;
  logic                              resend;
  logic                              pop_ok;
  logic [arqsw_pkg::SEQ_W:0]         pop_raw;
  logic [arqsw_pkg::CNT_W-1:0]       pop_n;
  logic [arqsw_pkg::SUM_W-1:0]       rsum;

  logic proc_fire;
  logic out_take;
  logic cfg_write;

  // Handshake control.
  assign out_take  = out_full && out_ready;
  assign proc_fire = item_valid && (!out_full || (out_ready && !pend_valid));
  assign in_ready  = !item_valid || proc_fire;

  // APB configuration access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == arqsw_pkg::REG_WINDOW_LIMIT) ?
                     arqsw_pkg::APB_DATA_W'(window_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= arqsw_pkg::WINDOW_LIMIT_RESET;
    end else if (cfg_write && paddr[2] == arqsw_pkg::REG_WINDOW_LIMIT) begin
      window_limit <= pwdata[arqsw_pkg::LIMIT_W-1:0];
    end
  end

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode <= arqsw_pkg::mode_t'(mode);
      item_tag  <= packet_tag;
      item_areq <= want_ack;
      item_aseq <= ack_seq;
      item_agen <= ack_generator;
    end
  end

  // Send path: full check and write slot behind the newest packet.
  always_comb begin
    window_full = (32'(held_count) >= 32'(window_limit)) ||
                  (32'(held_count) >= arqsw_pkg::WINDOW_DEPTH);
    wsum = arqsw_pkg::SUM_W'(read_pos) + arqsw_pkg::SUM_W'(held_count);
    if (wsum >= arqsw_pkg::SUM_W'(arqsw_pkg::WINDOW_DEPTH)) begin
      wsum = wsum - arqsw_pkg::SUM_W'(arqsw_pkg::WINDOW_DEPTH);
    end
    wpos = arqsw_pkg::PTR_W'(wsum);
  end

  // Ack path: receiver sequence update, resend decision and pop count.
  always_comb begin
    agen_newer = (item_agen >= receiver_seq) ||
                 ((receiver_seq - item_agen) > arqsw_pkg::WRAP_DIST);
    receiver_seq_next = agen_newer ? item_agen : receiver_seq;
    if (item_aseq >= receiver_seq_next) begin
      resend = (item_aseq - receiver_seq_next) > arqsw_pkg::WRAP_DIST;
    end else begin
      resend = (receiver_seq_next - item_aseq) <= arqsw_pkg::WRAP_DIST;
    end
    pop_ok = (held_count != '0) &&
             ((item_aseq >= head_seq) ||
              ((head_seq - item_aseq) > arqsw_pkg::WRAP_DIST));
    pop_raw = {1'b0, item_aseq - head_seq} + (arqsw_pkg::SEQ_W + 1)'(1);
    if (!pop_ok) begin
      pop_n = '0;
    end else if (32'(pop_raw) > 32'(held_count)) begin
      pop_n = held_count;
    end else begin
      pop_n = arqsw_pkg::CNT_W'(pop_raw);
    end
    rsum = arqsw_pkg::SUM_W'(read_pos) + arqsw_pkg::SUM_W'(pop_n);
    if (rsum >= arqsw_pkg::SUM_W'(arqsw_pkg::WINDOW_DEPTH)) begin
      rsum = rsum - arqsw_pkg::SUM_W'(arqsw_pkg::WINDOW_DEPTH);
    end
  end

  // Per-mode state update and result selection.
  always_comb begin
    next_seq_next = next_seq;
    head_seq_next = head_seq;
    held_count_next = held_count;
    read_pos_next = read_pos;
    store_wr = 1'b0;
    res_two = 1'b0;
    res0 = '{kind: arqsw_pkg::KIND_NONE, seq_number: '0, tag_out: '0,
             window_count: arqsw_pkg::COUNT_W'(held_count), last: 1'b1};
    res1 = res0;
    case (item_mode)
      arqsw_pkg::MODE_SEND: begin
        if (window_full) begin
          res0.kind = arqsw_pkg::KIND_REJECTED;
        end else begin
          store_wr = 1'b1;
          held_count_next = held_count + arqsw_pkg::CNT_W'(1);
          next_seq_next = next_seq + arqsw_pkg::SEQ_W'(1);
          res0.kind = arqsw_pkg::KIND_DATA;
          res0.seq_number = next_seq;
          res0.tag_out = item_tag;
          res0.window_count = arqsw_pkg::COUNT_W'(held_count_next);
          res0.last = !item_areq;
          res_two = item_areq;
          res1.kind = arqsw_pkg::KIND_ACK_REQ;
          res1.seq_number = next_seq;
          res1.window_count = arqsw_pkg::COUNT_W'(held_count_next);
        end
      end
      arqsw_pkg::MODE_ACK_REQ: begin
        if (held_count != '0) begin
          res0.kind = arqsw_pkg::KIND_ACK_REQ;
          res0.seq_number = head_seq + arqsw_pkg::SEQ_W'(held_count) -
                            arqsw_pkg::SEQ_W'(1);
        end
      end
      arqsw_pkg::MODE_ACK_IN: begin
        held_count_next = held_count - pop_n;
        head_seq_next = head_seq + arqsw_pkg::SEQ_W'(pop_n);
        read_pos_next = arqsw_pkg::PTR_W'(rsum);
        res0.window_count = arqsw_pkg::COUNT_W'(held_count_next);
        if (resend && held_count_next != '0) begin
          res0.kind = arqsw_pkg::KIND_RESEND;
          res0.seq_number = head_seq_next;
          res0.tag_out = tag_store[read_pos_next];
        end
      end
      default: begin
        res0.kind = arqsw_pkg::KIND_NONE;
      end
    endcase
  end

  // Window state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq     <= arqsw_pkg::SEQ_RESET;
      receiver_seq <= '0;
      head_seq     <= arqsw_pkg::SEQ_RESET;
      held_count   <= '0;
      read_pos     <= '0;
    end else if (proc_fire) begin
      next_seq   <= next_seq_next;
      head_seq   <= head_seq_next;
      held_count <= held_count_next;
      read_pos   <= read_pos_next;
      if (item_mode == arqsw_pkg::MODE_ACK_IN) begin
        receiver_seq <= receiver_seq_next;
      end
    end
  end

  // Retransmit tag storage.
  always_ff @(posedge clk) begin
    if (proc_fire && store_wr) begin
      tag_store[wpos] <= item_tag;
    end
  end

  // Output register and spill slot control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (proc_fire) begin
      out_full   <= 1'b1;
      pend_valid <= res_two;
    end else if (out_take) begin
      out_full   <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_q  <= res0;
      pend_q <= res1;
    end else if (out_take && pend_valid) begin
      out_q <= pend_q;
    end
  end

  // Result beat ports.
  assign out_valid    = out_full;
  assign kind         = out_q.kind;
  assign seq_number   = out_q.seq_number;
  assign tag_out      = out_q.tag_out;
  assign window_count = out_q.window_count;
  assign last         = out_q.last;

  // The window never holds more packets than it has slots.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held_count) <= arqsw_pkg::WINDOW_DEPTH)
    else $error("held_count exceeds window depth");

  // A spilled second result only exists behind a full output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_full)
    else $error("spill slot valid with empty output register");

  // A data beat that is not last is always followed by its ack request.
  a_data_then_req: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_q.kind == arqsw_pkg::KIND_DATA && !out_q.last) |->
    (pend_valid && pend_q.kind == arqsw_pkg::KIND_ACK_REQ && pend_q.last))
    else $error("data beat without following ack request");

  // Taking a beat while a second result waits keeps the output valid.
  a_pend_advances: assert property (@(posedge clk) disable iff (rst)
    (out_take && pend_valid) |=> out_full)
    else $error("spilled result lost");

  // Reset empties the window and the result path.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (held_count == '0 && !out_full && !pend_valid && !item_valid))
    else $error("state not cleared by reset");

endmodule
